@@ rtl/student_t_score_volatility_filter_top_assert.svh @@
// assertion macros used by the top-level rtl
`ifndef STUDENT_T_SCORE_VOLATILITY_FILTER_TOP_ASSERT_SVH
`define STUDENT_T_SCORE_VOLATILITY_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define STSVF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stsvf assertion failed");

// next-cycle implication
`define STSVF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stsvf assertion failed");

`endif

@@ rtl/stsvf_pkg.sv @@
package stsvf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOCATION   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERCEPT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERSIST    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOF        = 3'd4;

    localparam logic [31:0] RST_LOCATION  = 32'd0;
    localparam logic [30:0] RST_INTERCEPT = 31'd6554;
    localparam logic [30:0] RST_WEIGHT    = 31'd3277;
    localparam logic [15:0] RST_PERSIST   = 16'd58982;
    localparam logic [31:0] RST_DOF       = 32'd327680;

    localparam int UNIT_STEPS = 64;

    // operation sequence, in execution order
    typedef enum logic [3:0] {
        OP_H0,   // initial variance divide
        OP_AM,   // alpha * (nu + 3)
        OP_AD,   // score gain divide
        OP_NC,   // tail scale divide
        OP_E2,   // squared deviation
        OP_S,    // h * (nu - 2)
        OP_ES,   // e2 * s
        OP_Q,    // e2*s / (s + e2)
        OP_W,    // tail scale * q
        OP_B,    // omega + beta * h
        OP_R     // gain * |w - h| and final update
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
        logic wb;
        logic capture;
        logic ld_out;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
    } t_stat;

    function automatic logic op_is_div(input t_op op);
        return (op == OP_H0) || (op == OP_AD) || (op == OP_NC) || (op == OP_Q);
    endfunction

endpackage

@@ rtl/stsvf_mul.sv @@
module stsvf_mul
    import stsvf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_busy,
    output logic [127:0] o_prod
);
    logic [128:0] r_p, n_p;
    logic [63:0]  r_a;
    logic [6:0]   r_cnt;
    logic [64:0]  hi;

    // shift-add, one multiplier bit per cycle
    always_comb begin
        hi = r_p[128:64];
        if (r_p[0]) begin
            hi = r_p[128:64] + {1'b0, r_a};
        end
        n_p = {1'b0, hi, r_p[63:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'(UNIT_STEPS);
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= {65'd0, i_b};
            r_a <= i_a;
        end else if (r_cnt != 0) begin
            r_p <= n_p;
        end
    end

    assign o_busy = (r_cnt != 0);
    assign o_prod = r_p[127:0];
endmodule

@@ rtl/stsvf_div.sv @@
module stsvf_div
    import stsvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_d,
    output logic        o_busy,
    output logic [63:0] o_q
);
    logic [63:0] r_rem, r_lo, r_q, r_d;
    logic [6:0]  r_cnt;
    logic [64:0] r2, diff;
    logic        ge;

    // restoring division, quotient known to fit 64 bits so upper half seeds the remainder
    always_comb begin
        r2   = {r_rem, r_lo[63]};
        diff = r2 - {1'b0, r_d};
        ge   = (r2 >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'(UNIT_STEPS);
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_d   <= i_d;
            r_q   <= '0;
        end else if (r_cnt != 0) begin
            r_rem <= ge ? diff[63:0] : r2[63:0];
            r_lo  <= {r_lo[62:0], 1'b0};
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_busy = (r_cnt != 0);
    assign o_q    = r_q;
endmodule

@@ rtl/stsvf_dp.sv @@
module stsvf_dp
    import stsvf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [31:0]           i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]           i_cfg_data,
    output logic [31:0]           o_variance,
    output logic                  o_saturated
);
    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

    logic [31:0] r_loc, r_nu;
    logic [30:0] r_omega, r_alpha;
    logic [15:0] r_beta;

    logic [31:0] r_y, r_h, r_a, r_nc, r_ovar;
    logic [63:0] r_e2, r_s, r_q, r_w, r_base;
    logic        r_sat, r_osat;

    logic         m_start, d_start, m_busy, d_busy;
    logic [63:0]  m_a, m_b, d_hi, d_lo, d_d, dq;
    logic [127:0] prod, psh;

    logic [63:0]  nu64, sum, diff, plo, tlo;
    logic [31:0]  nm2;
    logic [32:0]  dev, mag;
    logic         nu_le2, w_ge, thi;
    logic [64:0]  up;

    stsvf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m_a), .i_b(m_b), .o_busy(m_busy), .o_prod(prod)
    );

    stsvf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_hi(d_hi), .i_lo(d_lo), .i_d(d_d), .o_busy(d_busy), .o_q(dq)
    );

    assign o_stat.mul_busy = m_busy;
    assign o_stat.div_busy = d_busy;

    always_comb begin
        nu64   = {32'd0, r_nu};
        nu_le2 = (nu64 <= (ONE << 1));
        nm2    = nu_le2 ? 32'd0 : r_nu - 32'(ONE << 1);
        dev    = {r_y[31], r_y} - {r_loc[31], r_loc};
        mag    = dev[32] ? (33'd0 - dev) : dev;
        sum    = r_e2 + r_s;
        w_ge   = (r_w >= {32'd0, r_h});
        diff   = w_ge ? (r_w - {32'd0, r_h}) : ({32'd0, r_h} - r_w);
        psh    = prod >> FRAC_BITS;
        plo    = prod[63:0] >> FRAC_BITS;
        thi    = |psh[127:64];
        tlo    = psh[63:0];
        up     = {1'b0, r_base} + {1'b0, tlo};
    end

    // operand selection for the shared units
    always_comb begin
        m_start = i_cmd.start && !op_is_div(i_cmd.op);
        d_start = i_cmd.start && op_is_div(i_cmd.op);
        m_a = '0;
        m_b = '0;
        d_hi = '0;
        d_lo = '0;
        d_d  = '0;
        case (i_cmd.op)
            OP_H0: begin
                d_lo = {33'd0, r_omega} << FRAC_BITS;
                d_d  = ONE - {48'd0, r_beta};
            end
            OP_AM: begin
                m_a = {33'd0, r_alpha};
                m_b = nu64 + 3 * ONE;
            end
            OP_AD: begin
                d_hi = prod[127:64];
                d_lo = prod[63:0];
                d_d  = nu64;
            end
            OP_NC: begin
                d_lo = (nu64 + ONE) << FRAC_BITS;
                d_d  = nu64 - (ONE << 1);
            end
            OP_E2: begin
                m_a = {31'd0, mag};
                m_b = {31'd0, mag};
            end
            OP_S: begin
                m_a = {32'd0, r_h};
                m_b = {32'd0, nm2};
            end
            OP_ES: begin
                m_a = r_e2;
                m_b = r_s;
            end
            OP_Q: begin
                d_hi = prod[127:64];
                d_lo = prod[63:0];
                d_d  = sum;
            end
            OP_W: begin
                m_a = {32'd0, r_nc};
                m_b = r_q;
            end
            OP_B: begin
                m_a = {48'd0, r_beta};
                m_b = {32'd0, r_h};
            end
            OP_R: begin
                m_a = {32'd0, r_a};
                m_b = diff;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc   <= RST_LOCATION;
            r_omega <= RST_INTERCEPT;
            r_alpha <= RST_WEIGHT;
            r_beta  <= RST_PERSIST;
            r_nu    <= RST_DOF;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOCATION:  r_loc   <= i_cfg_data;
                CFG_INTERCEPT: r_omega <= i_cfg_data[30:0];
                CFG_WEIGHT:    r_alpha <= i_cfg_data[30:0];
                CFG_PERSIST:   r_beta  <= i_cfg_data[15:0];
                CFG_DOF:       r_nu    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h  <= '0;
            r_a  <= '0;
            r_nc <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_y   <= i_sample;
                r_sat <= 1'b0;
            end
            if (i_cmd.ld_out) begin
                r_ovar <= r_h;
                r_osat <= r_sat;
            end
            if (i_cmd.wb) begin
                case (i_cmd.op)
                    OP_H0: begin
                        if ({48'd0, r_beta} >= ONE || dq > MAX32) begin
                            r_h   <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_h <= dq[31:0];
                        end
                    end
                    OP_AD: r_a  <= (r_nu == 0 || dq > MAX32) ? '1 : dq[31:0];
                    OP_NC: r_nc <= (nu_le2 || dq > MAX32) ? '1 : dq[31:0];
                    OP_E2: r_e2 <= plo;
                    OP_S:  r_s  <= plo;
                    OP_Q:  r_q  <= dq;
                    OP_W: begin
                        if (r_s == 0 || sum == 0) begin
                            r_w <= '0;
                        end else begin
                            r_w <= thi ? '1 : tlo;
                        end
                    end
                    OP_B: r_base <= plo + {33'd0, r_omega};
                    OP_R: begin
                        if (w_ge) begin
                            if (thi || tlo > MAX32 || up > {1'b0, MAX32}) begin
                                r_h   <= '1;
                                r_sat <= 1'b1;
                            end else begin
                                r_h <= up[31:0];
                            end
                        end else if (thi || tlo > r_base) begin
                            r_h   <= '0;
                            r_sat <= 1'b1;
                        end else if ((r_base - tlo) > MAX32) begin
                            r_h   <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_h <= 32'(r_base - tlo);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_variance  = r_ovar;
    assign o_saturated = r_osat;
endmodule

@@ rtl/stsvf_ctrl.sv @@
module stsvf_ctrl
    import stsvf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_start_req,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_OP, S_OUT} t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_wait, r_primed, r_ovalid;
    logic   unit_busy;

    always_comb begin
        unit_busy     = op_is_div(r_op) ? i_stat.div_busy : i_stat.mul_busy;
        o_cmd.op      = r_op;
        o_cmd.start   = (r_state == S_OP) && !r_wait;
        o_cmd.wb      = (r_state == S_OP) && r_wait && !unit_busy;
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.ld_out  = (r_state == S_OUT) && (!r_ovalid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_H0;
            r_wait   <= 1'b0;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_wait  <= 1'b0;
                        r_state <= S_OP;
                        if (i_start_req || !r_primed) begin
                            r_op     <= OP_H0;
                            r_primed <= 1'b1;
                        end else begin
                            r_op <= OP_E2;
                        end
                    end
                end
                S_OP: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (!unit_busy) begin
                        r_wait <= 1'b0;
                        if (r_op == OP_R) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op <= t_op'(r_op + 4'd1);
                        end
                    end
                end
                S_OUT: begin
                    if (o_cmd.ld_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
endmodule

@@ rtl/student_t_score_volatility_filter_top.sv @@
// channel     dir  data                      side
// s_axis      in   tdata: sample             tuser: start_req
// m_axis      out  tdata: variance           tuser: saturated
// cfg         in   i_cfg_data by i_cfg_addr  write on i_cfg_we
// the gains and h are reinitialized on start_req or on the first sample after reset
// every operation is a start, 64 steps of the shift-add multiplier or the
// restoring divider, and a write-back; 7 operations per sample, 4 more on init
// reset is synchronous, active low; it restores the register defaults and clears primed
// a result waits in the output register while the next sample is accepted
`include "student_t_score_volatility_filter_top_assert.svh"

module student_t_score_volatility_filter_top
    import stsvf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // sample
    input  logic                  s_axis_tuser,   // start_req
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // variance
    output logic                  m_axis_tuser,   // saturated
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]           i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    stsvf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_start_req(s_axis_tuser), .o_ready(s_axis_tready),
        .o_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    stsvf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_sample(s_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .o_variance(m_axis_tdata), .o_saturated(m_axis_tuser)
    );

    `STSVF_ASSERT_IMPL(a_start_idle, cmd.start, !stat.mul_busy && !stat.div_busy)
    `STSVF_ASSERT_NEXT(a_start_runs, cmd.start, stat.mul_busy || stat.div_busy)
    `STSVF_ASSERT_IMPL(a_ready_idle, s_axis_tready, !stat.mul_busy && !stat.div_busy)
    `STSVF_ASSERT_NEXT(a_load_valid, cmd.ld_out, m_axis_tvalid)
endmodule

@@ tb/tb_student_t_score_volatility_filter_top.sv @@
`timescale 1ns / 100ps

module tb_student_t_score_volatility_filter_top;
    import stsvf_pkg::*;

    localparam int FB = 16;
    localparam logic [63:0] ONE_Q = 64'd1 << FB;
    localparam logic [63:0] ALL32 = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [31:0] sample;
        logic        restart;
    } t_request;

    typedef struct {
        logic [31:0] variance;
        logic        saturated;
    } t_variance;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // sample
    logic                  s_axis_tuser;   // start_req
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // variance
    logic                  m_axis_tuser;   // saturated
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [31:0]           i_cfg_data;

    student_t_score_volatility_filter_top u_top (.*);

    // mirror of the filter registers and state
    logic [63:0] mu_q, omega_q, alpha_q, beta_q, nu_q;
    logic [63:0] h_state, gain_a, nu_con;
    logic        primed_q;

    t_request  pending_q[$];
    t_variance variance_exp_q[$];

    int tx_idle, rx_idle;
    int hold_off_cycles;
    int cycle_count;
    int errors;
    int samples_sent, results_seen, sat_seen, restarts_sent;
    bit in_taken;

    initial begin
        i_clk = 0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t: %0d results outstanding", $time, variance_exp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic init_filter();
        logic [127:0] p;
        logic [63:0]  h0;
        logic         sat;
        sat = 1'b0;
        if (beta_q >= ONE_Q) begin
            h_state = ALL32;
            sat = 1'b1;
        end else begin
            h0 = (omega_q << FB) / (ONE_Q - beta_q);
            if (h0 > ALL32) begin
                h0 = ALL32;
                sat = 1'b1;
            end
            h_state = h0;
        end
        if (nu_q == 0) begin
            gain_a = ALL32;
        end else begin
            p = ({64'b0, alpha_q} * {64'b0, nu_q + 3 * ONE_Q}) / {64'b0, nu_q};
            gain_a = (p[63:0] > ALL32) ? ALL32 : p[63:0];
        end
        if (nu_q <= 2 * ONE_Q) begin
            nu_con = ALL32;
        end else begin
            h0 = ((nu_q + ONE_Q) << FB) / (nu_q - 2 * ONE_Q);
            nu_con = (h0 > ALL32) ? ALL32 : h0;
        end
        return sat;
    endfunction

    function automatic t_variance predict_variance(t_request r);
        logic [127:0] p;
        logic [63:0]  h, nm2, mag, e2, s, sum, q, w, base, res;
        longint       d;
        logic         sat;
        t_variance    v;
        sat = 1'b0;
        if (r.restart || !primed_q) begin
            sat = init_filter();
            primed_q = 1'b1;
        end
        h = h_state;
        d = longint'($signed(r.sample)) - longint'($signed(mu_q[31:0]));
        mag = (d < 0) ? -d : d;
        e2 = (mag * mag) >> FB;
        nm2 = (nu_q > 2 * ONE_Q) ? nu_q - 2 * ONE_Q : 64'd0;
        s = (h * nm2) >> FB;
        sum = s + e2;
        if (s == 0 || sum == 0) begin
            w = 0;
        end else begin
            p = ({64'b0, e2} * {64'b0, s}) / {64'b0, sum};
            q = p[63:0];
            p = ({64'b0, nu_con} * {64'b0, q}) >> FB;
            w = (p[127:64] != 0) ? '1 : p[63:0];
        end
        base = ((beta_q * h) >> FB) + omega_q;
        if (w >= h) begin
            p = ({64'b0, gain_a} * {64'b0, w - h}) >> FB;
            if (p[127:32] != 0 || base + p[63:0] > ALL32) begin
                res = ALL32;
                sat = 1'b1;
            end else begin
                res = base + p[63:0];
            end
        end else begin
            p = ({64'b0, gain_a} * {64'b0, h - w}) >> FB;
            if (p[127:64] != 0 || p[63:0] > base) begin
                res = 0;
                sat = 1'b1;
            end else begin
                res = base - p[63:0];
                if (res > ALL32) begin
                    res = ALL32;
                    sat = 1'b1;
                end
            end
        end
        h_state = res;
        v.variance = res[31:0];
        v.saturated = sat;
        return v;
    endfunction

    // request side: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            variance_exp_q.push_back(predict_variance(pending_q.pop_front()));
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_q[0].sample;
                s_axis_tuser  <= pending_q[0].restart;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // result side, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_variance exp_v;
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) sat_seen++;
            if (variance_exp_q.size() == 0) begin
                $display("%0t: unexpected result variance=%h sat=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_v = variance_exp_q.pop_front();
                if (m_axis_tdata !== exp_v.variance) begin
                    $display("%0t: variance expected %h actual %h",
                             $time, exp_v.variance, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_v.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_v.saturated, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LOCATION:  mu_q    = {32'b0, val};
            CFG_INTERCEPT: omega_q = {33'b0, val[30:0]};
            CFG_WEIGHT:    alpha_q = {33'b0, val[30:0]};
            CFG_PERSIST:   beta_q  = {48'b0, val[15:0]};
            CFG_DOF:       nu_q    = {32'b0, val};
            default: ;
        endcase
    endtask

    task automatic set_filter(logic [31:0] mu, logic [31:0] omega, logic [31:0] alpha,
                              logic [31:0] beta, logic [31:0] nu);
        write_reg(CFG_LOCATION, mu);
        write_reg(CFG_INTERCEPT, omega);
        write_reg(CFG_WEIGHT, alpha);
        write_reg(CFG_PERSIST, beta);
        write_reg(CFG_DOF, nu);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic [31:0] y, logic rs);
        t_request r;
        r.sample  = y;
        r.restart = rs;
        pending_q.push_back(r);
        samples_sent++;
        if (rs) restarts_sent++;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && variance_exp_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_dof();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd131072;
            2:       return 32'd131073;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom;
            default: return $urandom_range(32'd1_000_000, 32'd150_000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain_reg();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'd0;
            2:       return $urandom;
            default: return $urandom_range(32'd40_000, 32'd100);
        endcase
    endfunction

    initial begin
        logic [31:0] mu;
        int          span;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        i_cfg_we = 0;
        i_cfg_addr = CFG_LOCATION;
        i_cfg_data = 0;
        cycle_count = 0;
        errors = 0;
        hold_off_cycles = 0;
        tx_idle = 35;
        rx_idle = 63;
        mu_q = RST_LOCATION;
        omega_q = RST_INTERCEPT;
        alpha_q = RST_WEIGHT;
        beta_q = RST_PERSIST;
        nu_q = RST_DOF;
        h_state = 0;
        gain_a = 0;
        nu_con = 0;
        primed_q = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default registers, first sample primes the filter without a restart
        send(32'd0, 1'b0);
        send(32'h7FFF_FFFF, 1'b0);
        send(32'h8000_0000, 1'b0);
        send(32'h0001_0000, 1'b1);
        send(32'hFFFF_0000, 1'b0);
        send(32'h5555_5555, 1'b0);
        send(32'hAAAA_AAAA, 1'b1);
        drain();

        // extreme registers: h0 saturates, huge gains, both clamp directions
        set_filter(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF);
        send(32'h7FFF_FFFF, 1'b1);
        send(32'h8000_0000, 1'b0);
        send(32'h8000_0000, 1'b1);
        send(32'h0000_0000, 1'b0);
        drain();
        // zero nu with zero beta and zero weights, then nu exactly two and just above two
        set_filter(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
        send(32'h8000_0000, 1'b1);
        send(32'h7FFF_FFFF, 1'b0);
        drain();
        set_filter(32'h0, 32'd65536, 32'h7FFF_FFFF, 32'd0, 32'd131072);
        send(32'h0001_0000, 1'b1);
        send(32'h8000_0000, 1'b0);
        send(32'h0, 1'b1);
        drain();
        set_filter(32'h0, 32'd6554, 32'd3277, 32'd58982, 32'd131073);
        send(32'h0004_0000, 1'b1);
        send(32'hFFFC_0000, 1'b0);
        send(32'h0, 1'b0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 4) begin
                tx_idle = 35;
                rx_idle = 63;
            end else if (ph < 8) begin
                tx_idle = 63;
                rx_idle = 35;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            mu = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0008_0000) - 32'h0004_0000;
            set_filter(mu, pick_gain_reg(), pick_gain_reg(),
                       ($urandom_range(4) == 0) ? 32'($urandom_range(2) * 32767)
                                                : $urandom_range(65000, 50000),
                       pick_dof());
            // stall the result side long enough for the input to back up
            if (ph == 2 || ph == 9) hold_off_cycles = 4000;
            span = 1 << $urandom_range(20, 14);
            for (int k = 0; k < 48; k++) begin
                if ($urandom_range(9) == 0)
                    send($urandom, $urandom_range(1));
                else
                    send(mu + $urandom_range(2 * span) - span, k == 0 || $urandom_range(24) == 0);
            end
            drain();
        end

        $display("sent %0d samples (%0d restarts) over 17 register settings, %0d results",
                 samples_sent, restarts_sent, results_seen);
        $display("%0d results came back saturated, %0d errors", sat_seen, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stsvf_pkg.sv
rtl/stsvf_mul.sv
rtl/stsvf_div.sv
rtl/stsvf_dp.sv
rtl/stsvf_ctrl.sv
rtl/student_t_score_volatility_filter_top.sv
tb/tb_student_t_score_volatility_filter_top.sv
